@@ hdl/mts_pkg.sv @@
// mts_pkg: sizes, operation and status codes and value helpers for the
// min tracking stack. No dependencies.
package mts_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int DEPTH_W     = 8;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic [ADDR_W-1:0]             addr_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // sign-extend the 32-bit field, keep the stored width
    function automatic value_t take_value(input logic signed [FIELD_W-1:0] raw);
        logic signed [63:0] ext;
        ext = 64'(raw);
        return ext[VALUE_WIDTH-1:0];
    endfunction

    // sign-extend a stored value, cut to the 32-bit field
    function automatic logic signed [FIELD_W-1:0] emit_value(input value_t v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[FIELD_W-1:0];
    endfunction

endpackage

@@ hdl/min_tracking_stack.sv @@
// min_tracking_stack: LIFO of signed values that reports its running minimum.
// Depends on mts_pkg for sizes, codes and value helpers.
//
// Usage: each input word on the in channel (in_valid/in_ready) is a push
// (opcode 0, push_value) or a pop (opcode 1). Every word yields exactly one
// result word on the out channel (out_valid/out_ready): popped value, minimum
// after the operation, depth, empty flag and status (ok, overflow, underflow).
// The tops of both stacks sit in registers; the entries themselves live in
// two memories, each with a write port and a separate registered read port.
// Latency: a push or any refused word shows its result in the cycle after
// acceptance; a successful pop passes through an extra fill state, because
// the new tops are read back from the memories before the result is shown.
// Throughput: one word at a time; the next word is taken only once the
// result of the last one has been taken, and a pop also waits for the
// memory refill of the tops.
// Reset: both counts clear, the stack is empty; memory contents are not
// cleared and no clearing pass runs.
// Stall: while out_ready is low the result word holds and in_ready stays low.
module min_tracking_stack (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 opcode,
    input  logic signed [mts_pkg::FIELD_W-1:0]   push_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mts_pkg::FIELD_W-1:0]   popped_value,
    output logic signed [mts_pkg::FIELD_W-1:0]   min_value,
    output logic [mts_pkg::DEPTH_W-1:0]          depth,
    output logic                                 is_empty,
    output logic [1:0]                           status
);
    import mts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FILL = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    count_t     vc_reg, vc_next;
    count_t     mc_reg, mc_next;
    value_t     val_top_reg, val_top_next;
    value_t     min_top_reg, min_top_next;
    value_t     popped_reg, popped_next;
    logic [1:0] status_reg, status_next;
    logic       min_pop_reg, min_pop_next;

    value_t value_mem [STACK_DEPTH];
    value_t min_mem   [STACK_DEPTH];
    value_t val_rd_reg, min_rd_reg;

    logic   val_we, min_we;
    addr_t  val_waddr, min_waddr;
    addr_t  val_raddr, min_raddr;
    value_t wdata;
    count_t vc_m2, mc_m2;
    logic   in_take;

    assign in_take = in_valid && (state_reg == S_IDLE);
    assign wdata   = take_value(push_value);
    assign vc_m2   = vc_reg - count_t'(2);
    assign mc_m2   = mc_reg - count_t'(2);

    // new tops after a pop sit one below the popped entry
    assign val_raddr = vc_m2[ADDR_W-1:0];
    assign min_raddr = mc_m2[ADDR_W-1:0];
    assign val_waddr = vc_reg[ADDR_W-1:0];
    assign min_waddr = mc_reg[ADDR_W-1:0];

    // operation sequencer
    always_comb
    begin
        state_next   = state_reg;
        vc_next      = vc_reg;
        mc_next      = mc_reg;
        val_top_next = val_top_reg;
        min_top_next = min_top_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        min_pop_next = min_pop_reg;
        val_we       = 1'b0;
        min_we       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    popped_next  = '0;
                    status_next  = ST_OK;
                    min_pop_next = 1'b0;
                    state_next   = S_OUT;
                    if (opcode == OP_PUSH)
                    begin
                        if (vc_reg == count_t'(STACK_DEPTH))
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            val_we       = 1'b1;
                            vc_next      = vc_reg + count_t'(1);
                            val_top_next = wdata;
                            if (mc_reg == '0 || wdata <= min_top_reg)
                            begin
                                min_we       = 1'b1;
                                mc_next      = mc_reg + count_t'(1);
                                min_top_next = wdata;
                            end
                        end
                    end
                    else
                    begin
                        if (vc_reg == '0)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            popped_next = val_top_reg;
                            vc_next     = vc_reg - count_t'(1);
                            if (mc_reg != '0 && val_top_reg == min_top_reg)
                            begin
                                mc_next      = mc_reg - count_t'(1);
                                min_pop_next = 1'b1;
                            end
                            state_next = S_FILL;
                        end
                    end
                end
            end
            S_FILL:
            begin
                if (vc_reg != '0)
                begin
                    val_top_next = val_rd_reg;
                end
                if (min_pop_reg && mc_reg != '0)
                begin
                    min_top_next = min_rd_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vc_reg      <= '0;
            mc_reg      <= '0;
            min_pop_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vc_reg      <= vc_next;
            mc_reg      <= mc_next;
            min_pop_reg <= min_pop_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_top_reg <= val_top_next;
        min_top_reg <= min_top_next;
        popped_reg  <= popped_next;
        status_reg  <= status_next;
    end

    // value and minimum memories, registered reads
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_waddr] <= wdata;
        end
        if (min_we)
        begin
            min_mem[min_waddr] <= wdata;
        end
        val_rd_reg <= value_mem[val_raddr];
        min_rd_reg <= min_mem[min_raddr];
    end

    // result word
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign popped_value = emit_value(popped_reg);
    assign min_value    = (vc_reg != '0 && mc_reg != '0) ? emit_value(min_top_reg) : '0;
    assign depth        = DEPTH_W'(vc_reg);
    assign is_empty     = (vc_reg == '0);
    assign status       = status_reg;

endmodule
